>>> hw/rtl/spw_pkg.sv
package spw_pkg;

    // Defaults for the top-level parameters.
    localparam int NUM_MODULES_DEF       = 2;
    localparam int MOTORS_PER_MODULE_DEF = 4;
    localparam int CLOCK_HZ_DEF          = 125000000;

    // Frame rate limits and reset value, in hertz.
    localparam logic [16:0] FREQ_MIN   = 17'd8;
    localparam logic [16:0] FREQ_MAX   = 17'd100000;
    localparam logic [16:0] FREQ_RESET = 17'd50;

    // Microseconds per second, dividend of the frame length.
    localparam logic [31:0] FRAME_US = 32'd1000000;

    // The divider counts in sixteenths; 4096 = 256 * 16 counter steps.
    localparam int          DIV_SCALE_SHIFT = 12;
    localparam logic [11:0] DIV16_MIN       = 12'd16;
    localparam logic [11:0] DIV16_MAX       = 12'd4095;

    localparam logic [7:0] LETTER_BASE = 8'h41;
    localparam logic [7:0] DIGIT_BASE  = 8'h30;

    localparam int DIV_W = 32;

    localparam logic [1:0] ACT_START   = 2'd0;
    localparam logic [1:0] ACT_REQUEST = 2'd1;
    localparam logic [1:0] ACT_TICK    = 2'd2;

    localparam logic [1:0] KIND_START  = 2'd0;
    localparam logic [1:0] KIND_ANSWER = 2'd1;
    localparam logic [1:0] KIND_LEVEL  = 2'd2;

    typedef struct packed {
        logic busy;
        logic done;
    } spw_div_status_t;

endpackage

>>> hw/rtl/servo_pulse_width_scheduler_top.sv
// Channel   Direction  Handshake                 Word
// command   in         start / busy              action, id_letter, id_digit,
//                                                pulse_microseconds
// config    in         cfg_valid / cfg_ready     cfg_data (pwm_frequency)
// result    out        strobe, one cycle         kind, accepted, channel, level, last,
//                                                divider_whole, divider_fraction,
//                                                wrap_top, wrap_total
//
// A command is taken when start is high and busy is low; busy stays high while it works.
// Start runs two 32-step divisions on the shared divider, and a third on the first start.
// An accepted request runs one division.
// A wrap tick emits one level word per channel, one per cycle; busy stays high until the last.
// Results are registered and shown for one cycle; the receiver cannot stall them.
// Reset clears the level table, the latched frame and the wrap count at once.
module servo_pulse_width_scheduler_top
    import spw_pkg::*;
#(
    parameter int NUM_MODULES       = NUM_MODULES_DEF,
    parameter int MOTORS_PER_MODULE = MOTORS_PER_MODULE_DEF,
    parameter int CLOCK_HZ          = CLOCK_HZ_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  action,
    input  logic [7:0]  id_letter,
    input  logic [7:0]  id_digit,
    input  logic [15:0] pulse_microseconds,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [16:0] cfg_data,
    output logic        strobe,
    output logic [1:0]  kind,
    output logic        accepted,
    output logic [2:0]  channel,
    output logic [15:0] level,
    output logic        last,
    output logic [7:0]  divider_whole,
    output logic [3:0]  divider_fraction,
    output logic [15:0] wrap_top,
    output logic [31:0] wrap_total
);

    localparam int CHANNELS = NUM_MODULES * MOTORS_PER_MODULE;
    localparam int TW       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    localparam logic [31:0] CLK_WORD   = 32'(CLOCK_HZ);
    localparam logic [31:0] CLK16_WORD = {CLK_WORD[27:0], 4'b0000};

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_D1_GO    = 4'd1;
    localparam logic [3:0] S_D1_WAIT  = 4'd2;
    localparam logic [3:0] S_MUL      = 4'd3;
    localparam logic [3:0] S_D2_GO    = 4'd4;
    localparam logic [3:0] S_D2_WAIT  = 4'd5;
    localparam logic [3:0] S_D3_GO    = 4'd6;
    localparam logic [3:0] S_D3_WAIT  = 4'd7;
    localparam logic [3:0] S_RMUL     = 4'd8;
    localparam logic [3:0] S_RD_GO    = 4'd9;
    localparam logic [3:0] S_RD_WAIT  = 4'd10;
    localparam logic [3:0] S_TICK     = 4'd11;

    logic [3:0]  state_reg, state_next;
    logic [16:0] freq_cfg_reg, freq_cfg_next;
    logic [16:0] f_reg, f_next;
    logic [11:0] div16_reg, div16_next;
    logic [15:0] wrap_reg, wrap_next;
    logic [31:0] prod_reg, prod_next;
    logic [16:0] frame_reg, frame_next;
    logic [15:0] res_reg, res_next;
    logic        started_reg, started_next;
    logic [31:0] wrap_cnt_reg, wrap_cnt_next;
    logic [15:0] table_reg [CHANNELS];
    logic [15:0] table_next [CHANNELS];
    logic [TW-1:0] idx_reg, idx_next;
    logic [2:0]  chan_reg, chan_next;
    logic [15:0] us_reg, us_next;
    logic [TW-1:0] cnt_reg, cnt_next;

    logic        strobe_reg, strobe_next;
    logic [1:0]  kind_reg, kind_next;
    logic        accepted_reg, accepted_next;
    logic [2:0]  channel_reg, channel_next;
    logic [15:0] level_reg, level_next;
    logic        last_reg, last_next;
    logic [7:0]  dw_reg, dw_next;
    logic [3:0]  df_reg, df_next;
    logic [15:0] wt_reg, wt_next;
    logic [31:0] total_reg, total_next;

    logic            div_go;
    logic [31:0]     div_dividend;
    logic [31:0]     div_divisor;
    spw_div_status_t div_status;
    logic [31:0]     div_quo;
    logic [31:0]     div_rem;

    logic [16:0] mul_a;
    logic [15:0] mul_b;
    logic [32:0] mul_prod;

    logic [16:0] f_clamped;
    logic [7:0]  module_off;
    logic [7:0]  motor_off;
    logic        id_ok;
    logic [4:0]  idx_full;
    logic [13:0] div16_raw;
    logic [15:0] wrap_calc;
    logic [15:0] ticks_calc;

    spw_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .go        (div_go),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .status    (div_status),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;

    assign f_clamped = (freq_cfg_reg < FREQ_MIN) ? FREQ_MIN :
                       (freq_cfg_reg > FREQ_MAX) ? FREQ_MAX : freq_cfg_reg;

    // Id decode: byte differences wrap, so letters below 'A' land far out of range.
    assign module_off = id_letter - LETTER_BASE;
    assign motor_off  = id_digit - DIGIT_BASE;
    assign id_ok      = started_reg && (frame_reg != '0) && (id_digit != 8'd0) &&
                        (module_off < 8'(NUM_MODULES)) &&
                        (motor_off < 8'(MOTORS_PER_MODULE));
    assign idx_full   = {3'b000, module_off[1:0]} * 5'(MOTORS_PER_MODULE) +
                        {3'b000, motor_off[1:0]};

    assign div_go = (state_reg == S_D1_GO) || (state_reg == S_D2_GO) ||
                    (state_reg == S_D3_GO) || (state_reg == S_RD_GO);

    always_comb
    begin
        case (state_reg)
            S_D1_GO:
            begin
                div_dividend = CLK_WORD;
                div_divisor  = {3'b000, f_reg, {DIV_SCALE_SHIFT{1'b0}}};
            end
            S_D2_GO:
            begin
                div_dividend = CLK16_WORD;
                div_divisor  = prod_reg;
            end
            S_D3_GO:
            begin
                div_dividend = FRAME_US;
                div_divisor  = {15'd0, f_reg};
            end
            default:
            begin
                div_dividend = prod_reg;
                div_divisor  = {15'd0, frame_reg};
            end
        endcase
    end

    // One multiplier: divider16 times frequency for start, resolution times microseconds
    // for a request.
    assign mul_a    = (state_reg == S_MUL) ? f_reg : {1'b0, res_reg};
    assign mul_b    = (state_reg == S_MUL) ? {4'b0000, div16_reg} : us_reg;
    assign mul_prod = {16'd0, mul_a} * {17'd0, mul_b};

    // Rounded-up divider: ceiling of clock over frequency times 4096.
    assign div16_raw = div_quo[13:0] + {13'd0, (div_rem != '0)};

    assign wrap_calc  = (div_quo == '0) ? 16'd0 :
                        (div_quo > 32'd65536) ? 16'hFFFF : 16'(div_quo - 32'd1);
    assign ticks_calc = (div_quo > 32'd65535) ? 16'hFFFF : div_quo[15:0];

    always_comb
    begin
        state_next    = state_reg;
        freq_cfg_next = freq_cfg_reg;
        f_next        = f_reg;
        div16_next    = div16_reg;
        wrap_next     = wrap_reg;
        prod_next     = prod_reg;
        frame_next    = frame_reg;
        res_next      = res_reg;
        started_next  = started_reg;
        wrap_cnt_next = wrap_cnt_reg;
        table_next    = table_reg;
        idx_next      = idx_reg;
        chan_next     = chan_reg;
        us_next       = us_reg;
        cnt_next      = cnt_reg;

        strobe_next   = 1'b0;
        kind_next     = kind_reg;
        accepted_next = accepted_reg;
        channel_next  = channel_reg;
        level_next    = level_reg;
        last_next     = last_reg;
        dw_next       = dw_reg;
        df_next       = df_reg;
        wt_next       = wt_reg;
        total_next    = total_reg;

        if (cfg_valid && cfg_ready)
        begin
            freq_cfg_next = cfg_data;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    case (action)
                        ACT_START:
                        begin
                            f_next     = f_clamped;
                            state_next = S_D1_GO;
                        end
                        ACT_REQUEST:
                        begin
                            if (id_ok)
                            begin
                                idx_next   = idx_full[TW-1:0];
                                chan_next  = idx_full[2:0];
                                us_next    = pulse_microseconds;
                                state_next = S_RMUL;
                            end
                            else
                            begin
                                strobe_next   = 1'b1;
                                kind_next     = KIND_ANSWER;
                                accepted_next = 1'b0;
                                channel_next  = 3'd0;
                                level_next    = 16'd0;
                                last_next     = 1'b1;
                                dw_next       = 8'd0;
                                df_next       = 4'd0;
                                wt_next       = 16'd0;
                                total_next    = 32'd0;
                            end
                        end
                        ACT_TICK:
                        begin
                            wrap_cnt_next = wrap_cnt_reg + 32'd1;
                            cnt_next      = '0;
                            state_next    = S_TICK;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_D1_GO:
            begin
                state_next = S_D1_WAIT;
            end
            S_D1_WAIT:
            begin
                if (div_status.done)
                begin
                    if (div16_raw < {2'b00, DIV16_MIN})
                    begin
                        div16_next = DIV16_MIN;
                    end
                    else if (div16_raw > {2'b00, DIV16_MAX})
                    begin
                        div16_next = DIV16_MAX;
                    end
                    else
                    begin
                        div16_next = div16_raw[11:0];
                    end
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                prod_next  = mul_prod[31:0];
                state_next = S_D2_GO;
            end
            S_D2_GO:
            begin
                state_next = S_D2_WAIT;
            end
            S_D2_WAIT:
            begin
                if (div_status.done)
                begin
                    wrap_next = wrap_calc;
                    if (started_reg)
                    begin
                        strobe_next   = 1'b1;
                        kind_next     = KIND_START;
                        accepted_next = 1'b0;
                        channel_next  = 3'd0;
                        level_next    = 16'd0;
                        last_next     = 1'b1;
                        dw_next       = div16_reg[11:4];
                        df_next       = div16_reg[3:0];
                        wt_next       = wrap_calc;
                        total_next    = 32'd0;
                        state_next    = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_D3_GO;
                    end
                end
            end
            S_D3_GO:
            begin
                state_next = S_D3_WAIT;
            end
            S_D3_WAIT:
            begin
                if (div_status.done)
                begin
                    frame_next    = div_quo[16:0];
                    res_next      = wrap_reg;
                    started_next  = 1'b1;
                    strobe_next   = 1'b1;
                    kind_next     = KIND_START;
                    accepted_next = 1'b0;
                    channel_next  = 3'd0;
                    level_next    = 16'd0;
                    last_next     = 1'b1;
                    dw_next       = div16_reg[11:4];
                    df_next       = div16_reg[3:0];
                    wt_next       = wrap_reg;
                    total_next    = 32'd0;
                    state_next    = S_IDLE;
                end
            end
            S_RMUL:
            begin
                prod_next  = mul_prod[31:0];
                state_next = S_RD_GO;
            end
            S_RD_GO:
            begin
                state_next = S_RD_WAIT;
            end
            S_RD_WAIT:
            begin
                if (div_status.done)
                begin
                    table_next[idx_reg] = ticks_calc;
                    strobe_next   = 1'b1;
                    kind_next     = KIND_ANSWER;
                    accepted_next = 1'b1;
                    channel_next  = chan_reg;
                    level_next    = ticks_calc;
                    last_next     = 1'b1;
                    dw_next       = 8'd0;
                    df_next       = 4'd0;
                    wt_next       = 16'd0;
                    total_next    = 32'd0;
                    state_next    = S_IDLE;
                end
            end
            S_TICK:
            begin
                strobe_next   = 1'b1;
                kind_next     = KIND_LEVEL;
                accepted_next = 1'b0;
                channel_next  = 3'(cnt_reg);
                level_next    = table_reg[cnt_reg];
                dw_next       = 8'd0;
                df_next       = 4'd0;
                wt_next       = 16'd0;
                total_next    = wrap_cnt_reg;
                cnt_next      = cnt_reg + 1'b1;
                last_next     = 1'b0;
                if (cnt_reg == TW'(CHANNELS - 1))
                begin
                    last_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            freq_cfg_reg <= FREQ_RESET;
            frame_reg    <= '0;
            res_reg      <= '0;
            started_reg  <= 1'b0;
            wrap_cnt_reg <= '0;
            strobe_reg   <= 1'b0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                table_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg    <= state_next;
            freq_cfg_reg <= freq_cfg_next;
            frame_reg    <= frame_next;
            res_reg      <= res_next;
            started_reg  <= started_next;
            wrap_cnt_reg <= wrap_cnt_next;
            strobe_reg   <= strobe_next;
            table_reg    <= table_next;
        end
    end

    always_ff @(posedge clk)
    begin
        f_reg        <= f_next;
        div16_reg    <= div16_next;
        wrap_reg     <= wrap_next;
        prod_reg     <= prod_next;
        idx_reg      <= idx_next;
        chan_reg     <= chan_next;
        us_reg       <= us_next;
        cnt_reg      <= cnt_next;
        kind_reg     <= kind_next;
        accepted_reg <= accepted_next;
        channel_reg  <= channel_next;
        level_reg    <= level_next;
        last_reg     <= last_next;
        dw_reg       <= dw_next;
        df_reg       <= df_next;
        wt_reg       <= wt_next;
        total_reg    <= total_next;
    end

    assign strobe           = strobe_reg;
    assign kind             = kind_reg;
    assign accepted         = accepted_reg;
    assign channel          = channel_reg;
    assign level            = level_reg;
    assign last             = last_reg;
    assign divider_whole    = dw_reg;
    assign divider_fraction = df_reg;
    assign wrap_top         = wt_reg;
    assign wrap_total       = total_reg;

`ifndef SYNTH
    // The sequencer never restarts the divider in the middle of a division.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_go |-> !div_status.busy)
        else $error("divider started while busy");

    // Once latched, the frame settings stay latched until reset.
    assert property (@(posedge clk) disable iff (!rst_n)
        started_reg |=> started_reg && $stable(frame_reg) && $stable(res_reg))
        else $error("latched frame settings changed");

    // Level words of one tick come out back to back.
    assert property (@(posedge clk) disable iff (!rst_n)
        strobe && (kind == KIND_LEVEL) && !last |=> strobe && (kind == KIND_LEVEL))
        else $error("gap in tick level words");

    // A rejected request carries no channel and no level.
    assert property (@(posedge clk) disable iff (!rst_n)
        strobe && (kind == KIND_ANSWER) && !accepted |-> (channel == 3'd0) &&
        (level == 16'd0) && last)
        else $error("rejected request answer carries data");
`endif

endmodule

>>> hw/rtl/spw_divider.sv
module spw_divider
    import spw_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               go,
    input  logic [DIV_W-1:0]   dividend,
    input  logic [DIV_W-1:0]   divisor,
    output spw_div_status_t    status,
    output logic [DIV_W-1:0]   quotient,
    output logic [DIV_W-1:0]   remainder
);

    localparam int CNT_W = $clog2(DIV_W);

    logic               run_reg, run_next;
    logic               done_reg, done_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [DIV_W-1:0]   quo_reg, quo_next;
    logic [DIV_W-1:0]   rem_reg, rem_next;
    logic [DIV_W-1:0]   dvsr_reg, dvsr_next;
    logic [DIV_W:0]     rem_shift;
    logic [DIV_W:0]     rem_diff;
    logic               fits;

    // One quotient bit per cycle, restoring form; the dividend shifts out of quo_reg.
    assign rem_shift = {rem_reg, quo_reg[DIV_W-1]};
    assign rem_diff  = rem_shift - {1'b0, dvsr_reg};
    assign fits      = (rem_shift >= {1'b0, dvsr_reg});

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvsr_next = dvsr_reg;
        if (go && !run_reg)
        begin
            run_next  = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
            dvsr_next = divisor;
        end
        else if (run_reg)
        begin
            quo_next = {quo_reg[DIV_W-2:0], fits};
            rem_next = fits ? rem_diff[DIV_W-1:0] : rem_shift[DIV_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DIV_W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        dvsr_reg <= dvsr_next;
    end

    assign status.busy = run_reg;
    assign status.done = done_reg;
    assign quotient    = quo_reg;
    assign remainder   = rem_reg;

endmodule
